// ===== src/u8v_pkg.sv =====
// Shared types and constants for the strict UTF-8 stream validator.
// Holds the byte classes, the queue entry and the result layout.
// Depends on nothing; used by every module of the block.
package u8v_pkg;

    // Lead and continuation byte limits
    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] LEAD_MIN    = 8'hC2;
    localparam logic [7:0] LEAD3_MIN   = 8'hE0;
    localparam logic [7:0] LEAD4_MIN   = 8'hF0;
    localparam logic [7:0] LEAD_MAX    = 8'hF4;
    localparam logic [7:0] LEAD_E0     = 8'hE0;
    localparam logic [7:0] LEAD_ED     = 8'hED;
    localparam logic [7:0] LEAD_F0     = 8'hF0;
    localparam logic [7:0] LEAD_F4     = 8'hF4;
    localparam logic [7:0] CONT_LO     = 8'h80;
    localparam logic [7:0] CONT_HI     = 8'hBF;
    localparam logic [7:0] E0_LO       = 8'hA0;
    localparam logic [7:0] ED_HI       = 8'h9F;
    localparam logic [7:0] F0_LO       = 8'h90;
    localparam logic [7:0] F4_HI       = 8'h8F;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        CLS_ASCII,
        CLS_CONT,
        CLS_BAD,
        CLS_LEAD2,
        CLS_LEAD3,
        CLS_LEAD4
    } byte_class_t;

    // One classified item between front and back
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        has_byte;
        logic        end_of_string;
        byte_class_t cls;
        logic [7:0]  lo_bound;
        logic [7:0]  hi_bound;
    } queue_entry_t;

    typedef struct packed {
        logic [20:0] code_point;
        logic [2:0]  byte_count;
        logic        point_ready;
        logic        error_seen;
        logic        string_done;
        logic        string_valid;
    } result_t;

endpackage

// ===== src/u8v_front.sv =====
// Front end: accepts input items and classifies each byte.
// Sets the continuation bounds for special leads. Uses u8v_pkg.
module u8v_front (
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            data_byte,
    input  logic                  has_byte,
    input  logic                  end_of_string,
    input  logic                  q_full,
    output logic                  q_push,
    output u8v_pkg::queue_entry_t q_entry
);

    u8v_pkg::byte_class_t cls;
    logic [7:0]           lo;
    logic [7:0]           hi;

    always_comb
    begin
        lo = u8v_pkg::CONT_LO;
        hi = u8v_pkg::CONT_HI;
        if (data_byte < u8v_pkg::ASCII_LIMIT)
        begin
            cls = u8v_pkg::CLS_ASCII;
        end
        else if (data_byte < u8v_pkg::LEAD_MIN)
        begin
            // continuation bytes plus C0/C1
            cls = (data_byte <= u8v_pkg::CONT_HI) ? u8v_pkg::CLS_CONT : u8v_pkg::CLS_BAD;
        end
        else if (data_byte > u8v_pkg::LEAD_MAX)
        begin
            cls = u8v_pkg::CLS_BAD;
        end
        else if (data_byte < u8v_pkg::LEAD3_MIN)
        begin
            cls = u8v_pkg::CLS_LEAD2;
        end
        else if (data_byte < u8v_pkg::LEAD4_MIN)
        begin
            cls = u8v_pkg::CLS_LEAD3;
            if (data_byte == u8v_pkg::LEAD_E0)
                lo = u8v_pkg::E0_LO;       // overlong
            else if (data_byte == u8v_pkg::LEAD_ED)
                hi = u8v_pkg::ED_HI;       // surrogates
        end
        else
        begin
            cls = u8v_pkg::CLS_LEAD4;
            if (data_byte == u8v_pkg::LEAD_F0)
                lo = u8v_pkg::F0_LO;       // overlong
            else if (data_byte == u8v_pkg::LEAD_F4)
                hi = u8v_pkg::F4_HI;       // above U+10FFFF
        end
    end

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb
    begin
        q_entry.data_byte     = data_byte;
        q_entry.has_byte      = has_byte;
        q_entry.end_of_string = end_of_string;
        q_entry.cls           = cls;
        q_entry.lo_bound      = lo;
        q_entry.hi_bound      = hi;
    end

endmodule

// ===== src/u8v_queue.sv =====
// Short queue of classified items between front and back.
// Register array with read and write pointers. Uses u8v_pkg.
module u8v_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  u8v_pkg::queue_entry_t push_entry,
    output logic                  full,
    input  logic                  pop,
    output logic                  not_empty,
    output u8v_pkg::queue_entry_t head
);

    u8v_pkg::queue_entry_t          mem_reg [u8v_pkg::QUEUE_DEPTH];
    logic [u8v_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [u8v_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [u8v_pkg::QPTR_W:0]       count_reg, count_next;

    assign full      = (count_reg == (u8v_pkg::QPTR_W+1)'(u8v_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

// ===== src/u8v_back.sv =====
// Back end: sequence state, code point assembly and verdicts.
// Pops classified items and fills the output register. Uses u8v_pkg.
module u8v_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_not_empty,
    input  u8v_pkg::queue_entry_t q_head,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output u8v_pkg::result_t      out_result
);

    logic [1:0]       needed_reg, needed_next;
    logic [20:0]      partial_reg, partial_next;
    logic [7:0]       lo_reg, lo_next;
    logic [7:0]       hi_reg, hi_next;
    logic [2:0]       len_reg, len_next;
    logic             failed_reg, failed_next;
    logic             valid_reg, valid_next;
    u8v_pkg::result_t res_reg, res_next;

    logic             emit;
    logic             err;
    logic [7:0]       b;
    u8v_pkg::result_t res;

    assign q_pop      = q_not_empty && (!valid_reg || out_ready);
    assign out_valid  = valid_reg;
    assign out_result = res_reg;
    assign b          = q_head.data_byte;

    always_comb
    begin
        needed_next  = needed_reg;
        partial_next = partial_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        len_next     = len_reg;
        failed_next  = failed_reg;
        emit         = 1'b0;
        err          = 1'b0;
        res          = '0;

        if (q_head.has_byte && !failed_reg)
        begin
            if (needed_reg == 2'd0)
            begin
                case (q_head.cls)
                    u8v_pkg::CLS_ASCII:
                    begin
                        res.code_point  = {13'd0, b};
                        res.byte_count  = 3'd1;
                        res.point_ready = 1'b1;
                        emit            = 1'b1;
                    end
                    u8v_pkg::CLS_LEAD2:
                    begin
                        needed_next  = 2'd1;
                        partial_next = {16'd0, b[4:0]};
                        len_next     = 3'd2;
                    end
                    u8v_pkg::CLS_LEAD3:
                    begin
                        needed_next  = 2'd2;
                        partial_next = {17'd0, b[3:0]};
                        len_next     = 3'd3;
                        lo_next      = q_head.lo_bound;
                        hi_next      = q_head.hi_bound;
                    end
                    u8v_pkg::CLS_LEAD4:
                    begin
                        needed_next  = 2'd3;
                        partial_next = {18'd0, b[2:0]};
                        len_next     = 3'd4;
                        lo_next      = q_head.lo_bound;
                        hi_next      = q_head.hi_bound;
                    end
                    default:
                    begin
                        err = 1'b1;   // stray continuation or bad lead
                    end
                endcase
            end
            else if (b < lo_reg || b > hi_reg)
            begin
                err = 1'b1;
            end
            else
            begin
                partial_next = {partial_reg[14:0], b[5:0]};
                lo_next      = u8v_pkg::CONT_LO;
                hi_next      = u8v_pkg::CONT_HI;
                needed_next  = needed_reg - 2'd1;
                if (needed_reg == 2'd1)
                begin
                    res.code_point  = partial_next;
                    res.byte_count  = len_reg;
                    res.point_ready = 1'b1;
                    emit            = 1'b1;
                    needed_next     = 2'd0;
                    partial_next    = '0;
                    len_next        = 3'd0;
                end
            end

            if (err)
            begin
                failed_next  = 1'b1;
                needed_next  = 2'd0;
                partial_next = '0;
                lo_next      = u8v_pkg::CONT_LO;
                hi_next      = u8v_pkg::CONT_HI;
                len_next     = 3'd0;
                emit         = 1'b1;
            end
        end

        if (q_head.end_of_string)
        begin
            if (!failed_next && needed_next != 2'd0)
            begin
                err         = 1'b1;   // truncated sequence
                failed_next = 1'b1;
            end
            res.string_done  = 1'b1;
            res.string_valid = !failed_next;
            emit             = 1'b1;
            needed_next      = 2'd0;
            partial_next     = '0;
            lo_next          = u8v_pkg::CONT_LO;
            hi_next          = u8v_pkg::CONT_HI;
            len_next         = 3'd0;
            failed_next      = 1'b0;
        end
        res.error_seen = err;

        valid_next = valid_reg && !out_ready;
        res_next   = res_reg;
        if (q_pop && emit)
        begin
            valid_next = 1'b1;
            res_next   = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needed_reg  <= 2'd0;
            partial_reg <= '0;
            lo_reg      <= u8v_pkg::CONT_LO;
            hi_reg      <= u8v_pkg::CONT_HI;
            len_reg     <= 3'd0;
            failed_reg  <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (q_pop)
            begin
                needed_reg  <= needed_next;
                partial_reg <= partial_next;
                lo_reg      <= lo_next;
                hi_reg      <= hi_next;
                len_reg     <= len_next;
                failed_reg  <= failed_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

// ===== src/utf8_strict_stream_validator_unit.sv =====
// Strict UTF-8 stream validator, top level. Uses u8v_pkg and the u8v_* modules.
// The queue writes the item at the input accept edge; the back end registers the result
// when it pops that item, and earlier items or a stalled output can hold that pop off.
// Throughput: 1 item per cycle while no result is held against a low m_axis_tready.
// Reset (rst_n low, async): queue empties, decode state returns to idle, no result held.
// Items that produce no result (lead bytes, swallowed bytes) still take a back-end pop.
module utf8_strict_stream_validator_unit (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] has_byte
    input  logic        s_axis_tlast,   // end_of_string
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [20:0] code_point, [23:21] byte_count
    output logic [2:0]  m_axis_tuser,   // [0] point_ready, [1] error_seen, [2] string_valid
    output logic        m_axis_tlast    // string_done
);

    // front -> queue
    logic                  q_push;
    logic                  q_full;
    u8v_pkg::queue_entry_t q_entry;
    // queue -> back
    logic                  q_pop;
    logic                  q_not_empty;
    u8v_pkg::queue_entry_t q_head;
    // back -> output
    u8v_pkg::result_t      result;

    // Front end classifies the byte as it is accepted; it stalls only on a full queue.
    u8v_front u_front (
        .s_valid       (s_axis_tvalid),
        .s_ready       (s_axis_tready),
        .data_byte     (s_axis_tdata),
        .has_byte      (s_axis_tuser),
        .end_of_string (s_axis_tlast),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_entry       (q_entry)
    );

    // Queue decouples input acceptance from output backpressure.
    u8v_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    // Back end runs the decoder state and owns the output register.
    u8v_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_result  (result)
    );

    assign m_axis_tdata = {result.byte_count, result.code_point};
    assign m_axis_tuser = {result.string_valid, result.error_seen, result.point_ready};
    assign m_axis_tlast = result.string_done;

endmodule
